// ===== sv/epd_pkg.sv =====
package epd_pkg;

    // Payload buffer sizing
    localparam int PAYLOAD_MAX = 64;
    localparam int IDX_W       = $clog2(PAYLOAD_MAX);
    localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int RAM_DEPTH   = 2 * PAYLOAD_MAX;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int LEN_W       = 7;

    // Checksum seed and the value of an empty checksum
    localparam logic [7:0]  SUM_SEED  = 8'hFF;
    localparam logic [15:0] SUM_EMPTY = {SUM_SEED, SUM_SEED};

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_LEN = 2'd0;
    localparam logic [1:0] ERR_HDR = 2'd1;
    localparam logic [1:0] ERR_ESC = 2'd2;
    localparam logic [1:0] ERR_SUM = 2'd3;

    // Configuration register indexes
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_ESCAPE = 1'b1;

    // Command from the parser to the output sequencer
    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       code;
        logic [7:0]       topic;
        logic [LEN_W-1:0] len;
        logic             bank;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // Payload buffer write port
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    // Output sequencer status: a payload burst has fully drained
    typedef struct packed {
        logic done;
        logic bank;
    } t_bk_stat;

endpackage

// ===== sv/escaped_packet_deframer_rx_unit.sv =====
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-------------------------------------------
// rx bytes  | s_axis_tvalid / s_axis_tready | s_axis_tdata[7:0] rx_byte
// results   | m_axis_tvalid / m_axis_tready | tuser kind, tdata fields, tlast last
// config    | i_cfg_valid / o_cfg_ready     | i_cfg_addr register index, i_cfg_data value
//
// The parser takes one rx byte per cycle while it has queue room; it stalls only when
// the payload bank it must fill is still draining (two banks alternate per good payload packet).
// Each payload byte is fetched in a load state (the buffer's registered read) and held in the
// output register until taken, so the next byte is not fetched before then. A result passes
// through the command queue and the output register; a payload byte also through the load state.
// Reset is synchronous, active low; no clearing pass is needed. Config is always ready.
module escaped_packet_deframer_rx_unit import epd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] error_code, [9:2] topic, [16:10] packet_length, [24:17] payload_byte, rest 0
    output logic [31:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    t_push             push;
    t_ram_wr           wr;
    t_bk_stat          bk;
    t_cmd              q_head;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [1:0]        busy;
    logic [RAM_AW-1:0] raddr;
    logic [7:0]        rdata;
    logic [1:0]        out_code;
    logic [7:0]        out_topic;
    logic [LEN_W-1:0]  out_len;
    logic [7:0]        out_byte;

    epd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (q_full),
        .i_bk          (bk),
        .o_push        (push),
        .o_wr          (wr),
        .o_busy        (busy)
    );

    epd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    epd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    epd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_head (q_head),
        .o_q_pop  (q_pop),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (m_axis_tuser),
        .o_code   (out_code),
        .o_topic  (out_topic),
        .o_len    (out_len),
        .o_byte   (out_byte),
        .o_last   (m_axis_tlast),
        .o_bk     (bk)
    );

    assign m_axis_tdata = {7'd0, out_byte, out_len, out_topic, out_code};

    // A command is only produced when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !q_full)
        else $error("command produced with queue full");

    // A drained burst always frees a bank that was marked busy
    a_free_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk.done |-> busy[bk.bank])
        else $error("burst completion on an idle bank");

    // Payload is never written into a bank that is still draining
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.we |-> !busy[wr.addr[RAM_AW-1]])
        else $error("payload write into a draining bank");

    // Error results are single items with zero topic and length
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_ERR) |->
            (m_axis_tlast && out_topic == 8'd0 && out_len == '0))
        else $error("malformed error result");

endmodule

// ===== sv/epd_ram.sv =====
module epd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/epd_front.sv =====
module epd_front import epd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       i_q_full,
    input  t_bk_stat   i_bk,
    output t_push      o_push,
    output t_ram_wr    o_wr,
    output logic [1:0] o_busy
);

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_CHK   = 3'd1,
        PH_TOPIC = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_ESC   = 3'd5
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_exp, n_exp;
    logic [7:0]       r_topic, n_topic;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_sum_a, n_sum_a;
    logic [7:0]       r_sum_b, n_sum_b;
    logic             r_wbank, n_wbank;
    logic [1:0]       r_busy, n_busy;
    logic [7:0]       r_hdr, r_esc;

    logic             accept;
    logic             storing;
    logic             do_store;
    logic [7:0]       b;
    logic [7:0]       sum_a_upd;
    logic [7:0]       sum_b_upd;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      len_word;

    assign b         = s_axis_tdata;
    assign storing   = (r_phase == PH_DATA) || (r_phase == PH_ESC);
    // Hold off while the bank being filled is still draining, or no queue room
    assign s_axis_tready = !i_q_full && !(storing && r_busy[r_wbank]);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign sum_a_upd = r_sum_a + b;
    assign sum_b_upd = r_sum_b + sum_a_upd;
    assign cnt_inc   = r_count + CNT_W'(1);
    assign len_word  = {r_len[7:0], b};
    assign o_cfg_ready = 1'b1;
    assign o_busy    = r_busy;

    // Parser next state
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_exp    = r_exp;
        n_topic  = r_topic;
        n_len    = r_len;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_wbank  = r_wbank;
        n_busy   = r_busy;
        do_store = 1'b0;
        o_push   = '0;
        o_wr     = '0;

        if (i_bk.done) begin
            n_busy[i_bk.bank] = 1'b0;
        end

        if (accept) begin
            unique case (r_phase)
                PH_CHK: begin
                    n_exp = {r_exp[7:0], b};
                    if (r_count >= CNT_W'(1)) begin
                        n_phase = PH_TOPIC;
                        n_count = '0;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                PH_TOPIC: begin
                    n_topic = b;
                    n_len   = '0;
                    n_count = '0;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len = len_word;
                    if (r_count < CNT_W'(1)) begin
                        n_count = cnt_inc;
                    end else begin
                        n_count = '0;
                        n_sum_a = SUM_SEED;
                        n_sum_b = SUM_SEED;
                        if (len_word > 16'(PAYLOAD_MAX)) begin
                            n_phase         = PH_WAIT;
                            o_push.valid    = 1'b1;
                            o_push.cmd.kind = KIND_ERR;
                            o_push.cmd.code = ERR_LEN;
                        end else if (len_word == 16'd0) begin
                            // Empty packet: checksum stays at its seed
                            n_phase      = PH_WAIT;
                            o_push.valid = 1'b1;
                            if (r_exp != SUM_EMPTY) begin
                                o_push.cmd.kind = KIND_ERR;
                                o_push.cmd.code = ERR_SUM;
                            end else begin
                                o_push.cmd.kind  = KIND_EMPTY;
                                o_push.cmd.topic = r_topic;
                            end
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (b == r_esc) begin
                        n_phase = PH_ESC;
                    end else if (b == r_hdr) begin
                        // Bare header restarts the packet
                        n_phase         = PH_CHK;
                        n_exp           = '0;
                        n_count         = '0;
                        o_push.valid    = 1'b1;
                        o_push.cmd.kind = KIND_ERR;
                        o_push.cmd.code = ERR_HDR;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (b == r_hdr || b == r_esc) begin
                        do_store = 1'b1;
                    end else begin
                        n_phase         = PH_WAIT;
                        o_push.valid    = 1'b1;
                        o_push.cmd.kind = KIND_ERR;
                        o_push.cmd.code = ERR_ESC;
                    end
                end
                default: begin
                    if (b == r_hdr) begin
                        n_phase = PH_CHK;
                        n_exp   = '0;
                        n_count = '0;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            endcase
        end

        // Store a payload byte, update the checksum, check for completion
        if (do_store) begin
            o_wr.we   = 1'b1;
            o_wr.addr = {r_wbank, r_count[IDX_W-1:0]};
            o_wr.data = b;
            n_count   = cnt_inc;
            n_sum_a   = sum_a_upd;
            n_sum_b   = sum_b_upd;
            if (16'(cnt_inc) >= r_len) begin
                n_phase      = PH_WAIT;
                o_push.valid = 1'b1;
                if ({sum_b_upd, sum_a_upd} != r_exp) begin
                    o_push.cmd.kind = KIND_ERR;
                    o_push.cmd.code = ERR_SUM;
                end else begin
                    o_push.cmd.kind  = KIND_DATA;
                    o_push.cmd.topic = r_topic;
                    o_push.cmd.len   = r_len[LEN_W-1:0];
                    o_push.cmd.bank  = r_wbank;
                    n_wbank          = !r_wbank;
                    n_busy[r_wbank]  = 1'b1;
                end
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    // Parser state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_count <= '0;
            r_exp   <= '0;
            r_topic <= '0;
            r_len   <= '0;
            r_sum_a <= SUM_SEED;
            r_sum_b <= SUM_SEED;
            r_wbank <= 1'b0;
            r_busy  <= '0;
            r_hdr   <= 8'd126;
            r_esc   <= 8'd125;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_exp   <= n_exp;
            r_topic <= n_topic;
            r_len   <= n_len;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
            if (i_cfg_valid && i_cfg_addr == REG_HEADER) begin
                r_hdr <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_addr == REG_ESCAPE) begin
                r_esc <= i_cfg_data;
            end
        end
    end

endmodule

// ===== sv/epd_cmdq.sv =====
module epd_cmdq import epd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_cmd  o_head
);

    t_cmd       r_ent [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_ent[r_rptr];
    assign push    = i_push.valid && !o_full;
    assign pop     = i_pop && o_valid;

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wptr] <= i_push.cmd;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== sv/epd_back.sv =====
module epd_back import epd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_head,
    output logic              o_q_pop,
    output logic [RAM_AW-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [1:0]        o_code,
    output logic [7:0]        o_topic,
    output logic [LEN_W-1:0]  o_len,
    output logic [7:0]        o_byte,
    output logic              o_last,
    output t_bk_stat          o_bk
);

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_LOAD = 2'd1,
        BK_OUT  = 2'd2
    } t_bk_state;

    t_bk_state        r_state;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [1:0]       r_kind;
    logic [1:0]       r_code;
    logic [7:0]       r_topic;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [IDX_W-1:0] idx_inc;
    logic             taken;

    assign idx_inc = r_idx + IDX_W'(1);
    assign taken   = r_valid && i_ready;
    assign o_q_pop = (r_state == BK_IDLE) && i_q_valid;

    // Read address is driven ahead of the data, which the buffer returns registered
    always_comb begin
        unique case (r_state)
            BK_IDLE: o_raddr = {i_q_head.bank, IDX_W'(0)};
            BK_OUT:  o_raddr = {r_cmd.bank, idx_inc};
            default: o_raddr = {r_cmd.bank, r_idx};
        endcase
    end

    assign o_bk.done = (r_state == BK_OUT) && taken && r_last && (r_kind == KIND_DATA);
    assign o_bk.bank = r_cmd.bank;

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                BK_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_head;
                        r_idx <= '0;
                        if (i_q_head.kind == KIND_DATA) begin
                            r_state <= BK_LOAD;
                        end else begin
                            r_kind  <= i_q_head.kind;
                            r_code  <= i_q_head.code;
                            r_topic <= i_q_head.topic;
                            r_len   <= i_q_head.len;
                            r_byte  <= '0;
                            r_last  <= 1'b1;
                            r_valid <= 1'b1;
                            r_state <= BK_OUT;
                        end
                    end
                end
                BK_LOAD: begin
                    r_kind  <= KIND_DATA;
                    r_code  <= '0;
                    r_topic <= r_cmd.topic;
                    r_len   <= r_cmd.len;
                    r_byte  <= i_rdata;
                    // Count in length width so a full 64-byte burst ends
                    r_last  <= ((LEN_W'(r_idx) + LEN_W'(1)) == r_cmd.len);
                    r_valid <= 1'b1;
                    r_state <= BK_OUT;
                end
                BK_OUT: begin
                    if (taken) begin
                        r_valid <= 1'b0;
                        if (r_kind == KIND_DATA && !r_last) begin
                            r_idx   <= idx_inc;
                            r_state <= BK_LOAD;
                        end else begin
                            r_state <= BK_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_code  = r_code;
    assign o_topic = r_topic;
    assign o_len   = r_len;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

// ===== tb/deframer_checker.sv =====
module deframer_checker import epd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic [1:0]  i_res_kind,
    input  logic        i_res_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] HDR_RESET  = 8'd126;
    localparam logic [7:0] ESC_RESET  = 8'd125;
    localparam logic [1:0] NO_CODE    = 2'd0;
    localparam int         MAX_REPORT = 10;

    typedef enum logic [2:0] {
        PH_HUNT, PH_SUM, PH_TOPIC, PH_LEN, PH_DATA, PH_ESC
    } rx_phase_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       code;
        logic [7:0]       topic;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic             last;
    } rx_result_t;

    // Mirror of the deframer state
    logic [7:0]  hdr_val;
    logic [7:0]  esc_val;
    rx_phase_t   phase;
    logic [6:0]  field_cnt;
    logic [15:0] want_sum;
    logic [7:0]  topic_q;
    logic [15:0] decl_len;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  payload_mem [PAYLOAD_MAX];

    rx_result_t  expected_results [$];
    int          fails = 0;

    task automatic push_result(input logic [1:0] kind, input logic [1:0] code,
                               input logic [7:0] topic, input logic [LEN_W-1:0] len,
                               input logic [7:0] data, input logic last);
        rx_result_t r;
        r.kind  = kind;
        r.code  = code;
        r.topic = topic;
        r.len   = len;
        r.data  = data;
        r.last  = last;
        expected_results.push_back(r);
    endtask

    task automatic push_error(input logic [1:0] code);
        push_result(KIND_ERR, code, 8'd0, '0, 8'd0, 1'b1);
    endtask

    // A header seen while hunting, or where payload was due, starts a fresh frame
    task automatic restart_frame();
        phase     = PH_SUM;
        want_sum  = '0;
        field_cnt = '0;
    endtask

    // Frame complete: compare checksum, then queue the payload bytes or an empty result, or flag error
    task automatic close_packet();
        int n;
        phase = PH_HUNT;
        n     = int'(decl_len);
        if ({sum_b, sum_a} != want_sum) begin
            push_error(ERR_SUM);
        end else if (n == 0) begin
            push_result(KIND_EMPTY, NO_CODE, topic_q, '0, 8'd0, 1'b1);
        end else begin
            for (int i = 0; i < n; i++)
                push_result(KIND_DATA, NO_CODE, topic_q, n[LEN_W-1:0], payload_mem[i],
                            i == n - 1);
        end
    endtask

    task automatic take_payload(input logic [7:0] b);
        if (field_cnt < PAYLOAD_MAX)
            payload_mem[field_cnt[IDX_W-1:0]] = b;
        field_cnt = field_cnt + 7'd1;
        sum_a     = sum_a + b;
        sum_b     = sum_b + sum_a;
        if (field_cnt >= decl_len)
            close_packet();
        else
            phase = PH_DATA;
    endtask

    // One received byte through the frame parser
    task automatic parse_rx_byte(input logic [7:0] b);
        case (phase)
            PH_SUM: begin
                want_sum = {want_sum[7:0], b};
                if (field_cnt >= 7'd1) begin
                    phase     = PH_TOPIC;
                    field_cnt = '0;
                end else begin
                    field_cnt = field_cnt + 7'd1;
                end
            end
            PH_TOPIC: begin
                topic_q   = b;
                decl_len  = '0;
                field_cnt = '0;
                phase     = PH_LEN;
            end
            PH_LEN: begin
                decl_len = {decl_len[7:0], b};
                if (field_cnt < 7'd1) begin
                    field_cnt = field_cnt + 7'd1;
                end else begin
                    field_cnt = '0;
                    sum_a     = SUM_SEED;
                    sum_b     = SUM_SEED;
                    if (decl_len > PAYLOAD_MAX) begin
                        phase = PH_HUNT;
                        push_error(ERR_LEN);
                    end else if (decl_len == 0) begin
                        close_packet();
                    end else begin
                        phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (b == esc_val) begin
                    phase = PH_ESC;
                end else if (b == hdr_val) begin
                    restart_frame();
                    push_error(ERR_HDR);
                end else begin
                    take_payload(b);
                end
            end
            PH_ESC: begin
                if (b == hdr_val || b == esc_val) begin
                    take_payload(b);
                end else begin
                    phase = PH_HUNT;
                    push_error(ERR_ESC);
                end
            end
            default: begin
                if (b == hdr_val)
                    restart_frame();
                else
                    phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic note_failure(input string what, input rx_result_t want,
                                input rx_result_t got);
        fails++;
        if (fails <= MAX_REPORT) begin
            $display("%0t: %s: exp kind=%0d code=%0d topic=%0h len=%0d data=%0h last=%0b",
                     $time, what, want.kind, want.code, want.topic, want.len, want.data,
                     want.last);
            $display("    got kind=%0d code=%0d topic=%0h len=%0d data=%0h last=%0b",
                     got.kind, got.code, got.topic, got.len, got.data, got.last);
        end
    endtask

    // Sample all channels at the clock edge; results are checked before the
    // byte of the same edge is parsed
    always @(posedge i_clk) begin
        rx_result_t got;
        rx_result_t want;
        if (!i_rst_n) begin
            hdr_val   = HDR_RESET;
            esc_val   = ESC_RESET;
            phase     = PH_HUNT;
            field_cnt = '0;
            want_sum  = '0;
            topic_q   = '0;
            decl_len  = '0;
            sum_a     = SUM_SEED;
            sum_b     = SUM_SEED;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_addr == REG_HEADER)
                    hdr_val = i_cfg_data;
                else
                    esc_val = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                got.kind  = i_res_kind;
                got.code  = i_res_data[1:0];
                got.topic = i_res_data[9:2];
                got.len   = i_res_data[16:10];
                got.data  = i_res_data[24:17];
                got.last  = i_res_last;
                if (expected_results.size() == 0) begin
                    note_failure("result with nothing expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind || got.code != want.code ||
                        got.topic != want.topic || got.len != want.len ||
                        got.data != want.data || got.last != want.last)
                        note_failure("result mismatch", want, got);
                end
            end
            if (i_rx_valid && i_rx_ready)
                parse_rx_byte(i_rx_byte);
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import epd_pkg::*;

    localparam int         HOLD_CYCLES = 600;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_BYTES = 4;
    localparam int         SETTLE      = 20;
    localparam logic [7:0] HDR_RESET   = 8'd126;
    localparam logic [7:0] ESC_RESET   = 8'd125;

    typedef enum {
        FR_GOOD, FR_BAD_SUM, FR_BARE_HDR, FR_BAD_ESC, FR_OVERFLOW, FR_NOISE
    } frame_kind_t;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_addr  = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;
    logic        rx_valid  = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_data   = 8'd0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_data;
    logic [1:0]  res_kind;
    logic        res_last;

    logic [7:0]  cur_hdr = HDR_RESET;
    logic [7:0]  cur_esc = ESC_RESET;
    logic [7:0]  frame_data [PAYLOAD_MAX];
    bit          no_idle   = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_started = 1'b0;
    int          bytes_sent  = 0;
    int          cycle_count = 0;
    int          fail_count;
    int          pending;

    always #5 i_clk = ~i_clk;

    escaped_packet_deframer_rx_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (rx_valid),
        .s_axis_tready (rx_ready),
        .s_axis_tdata  (rx_data),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data),
        .m_axis_tuser  (res_kind),
        .m_axis_tlast  (res_last)
    );

    deframer_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .i_rx_valid   (rx_valid),
        .i_rx_ready   (rx_ready),
        .i_rx_byte    (rx_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .i_res_kind   (res_kind),
        .i_res_last   (res_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random byte that carries no framing meaning
    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        v = 8'($urandom);
        while (v == cur_hdr || v == cur_esc)
            v = 8'($urandom);
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        do @(posedge i_clk); while (!rx_ready);
        bytes_sent++;
    endtask

    task automatic send_stuffed(input logic [7:0] b);
        if (b == cur_hdr || b == cur_esc)
            send_byte(cur_esc);
        send_byte(b);
    endtask

    // Header, big-endian checksum, topic, big-endian length
    task automatic send_fields(input logic [15:0] chk, input logic [7:0] topic,
                               input logic [15:0] len);
        send_byte(cur_hdr);
        send_byte(chk[15:8]);
        send_byte(chk[7:0]);
        send_byte(topic);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_frame(input frame_kind_t fk, input int len, input bit fill);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] chk;
        int          cut;
        case (fk)
            FR_NOISE: begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            FR_OVERFLOW: begin
                send_fields(16'($urandom), 8'($urandom),
                            16'($urandom_range(PAYLOAD_MAX + 1, 16'hFFFF)));
            end
            FR_BAD_ESC: begin
                send_fields(16'($urandom), 8'($urandom), 16'(len));
                cut = $urandom_range(0, len - 1);
                repeat (cut) send_byte(plain_byte());
                send_byte(cur_esc);
                send_byte(plain_byte());
            end
            default: begin
                // Truncated frame: the header of the following good frame lands in payload
                if (fk == FR_BARE_HDR) begin
                    send_fields(16'($urandom), 8'($urandom), 16'(len));
                    cut = $urandom_range(0, len - 1);
                    repeat (cut) send_byte(plain_byte());
                end
                if (fill)
                    for (int i = 0; i < len; i++)
                        frame_data[i] = 8'($urandom);
                a = SUM_SEED;
                b = SUM_SEED;
                for (int i = 0; i < len; i++) begin
                    a = a + frame_data[i];
                    b = b + a;
                end
                chk = {b, a};
                if (fk == FR_BAD_SUM)
                    chk = chk ^ 16'($urandom_range(1, 16'hFFFF));
                send_fields(chk, 8'($urandom), 16'(len));
                for (int i = 0; i < len; i++)
                    send_stuffed(frame_data[i]);
            end
        endcase
    endtask

    task automatic random_frame();
        int          r;
        int          len;
        frame_kind_t fk;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(0, 8);
        else if (r < 95)
            len = $urandom_range(9, 24);
        else
            len = PAYLOAD_MAX;
        r = $urandom_range(0, 99);
        if (r < 60)
            fk = FR_GOOD;
        else if (r < 70)
            fk = FR_BAD_SUM;
        else if (r < 78)
            fk = FR_BARE_HDR;
        else if (r < 86)
            fk = FR_BAD_ESC;
        else if (r < 93)
            fk = FR_OVERFLOW;
        else
            fk = FR_NOISE;
        // With header equal to escape a bare header cannot exist
        if (fk == FR_BARE_HDR && cur_hdr == cur_esc)
            fk = FR_GOOD;
        if ((fk == FR_BARE_HDR || fk == FR_BAD_ESC) && len == 0)
            len = 1;
        send_frame(fk, len, 1'b1);
    endtask

    // Stop offering bytes and wait for every expected result
    task automatic quiesce(input int settle);
        rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [7:0] hdr, input logic [7:0] esc);
        cfg_valid <= 1'b1;
        cfg_addr  <= REG_HEADER;
        cfg_data  <= hdr;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_addr  <= REG_ESCAPE;
        cfg_data  <= esc;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_hdr = hdr;
        cur_esc = esc;
    endtask

    // Result sink with random stalls and one long hold-off on request
    initial begin
        int  gap;
        bit  held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                hold_started = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            gap = idle_cycles();
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under reset framing bytes
        send_frame(FR_GOOD, 0, 1'b0);
        send_frame(FR_BAD_SUM, 0, 1'b0);
        send_frame(FR_OVERFLOW, 0, 1'b0);
        frame_data[0] = cur_hdr;
        frame_data[1] = cur_esc;
        send_frame(FR_GOOD, 2, 1'b0);
        quiesce(SETTLE);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: load_config(8'h00, 8'hFF);
                1: load_config(8'hFF, 8'h00);
                2: load_config(8'h5A, 8'h5A);
                3: load_config(8'($urandom), 8'($urandom));
                default: load_config(HDR_RESET, ESC_RESET);
            endcase
            // Sink holds off while good frames keep arriving: both banks fill up
            if (p == 0) begin
                hold_req <= 1'b1;
                while (!hold_started)
                    @(posedge i_clk);
                no_idle = 1'b1;
                repeat (3) send_frame(FR_GOOD, $urandom_range(4, 8), 1'b1);
            end
            no_idle = (p == 1);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                random_frame();
            no_idle = 1'b0;
            quiesce(SETTLE);
        end
        repeat (100) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/epd_pkg.sv
sv/epd_ram.sv
sv/epd_front.sv
sv/epd_cmdq.sv
sv/epd_back.sv
sv/escaped_packet_deframer_rx_unit.sv
tb/deframer_checker.sv
tb/tb_top.sv
